/* rtl/bgc_pkg.sv */
package bgc_pkg;

  localparam int unsigned CfgWidth    = 16;
  localparam int unsigned CfgIdxWidth = 3;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_DEBOUNCE   = 3'd0,
    CFG_CLICK_MAX  = 3'd1,
    CFG_SHORT_MAX  = 3'd2,
    CFG_LONG_HOLD  = 3'd3,
    CFG_DOUBLE_GAP = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_CLICK  = 3'd1,
    EV_DOUBLE = 3'd2,
    EV_SHORT  = 3'd3,
    EV_LONG   = 3'd4
  } event_code_e;

  localparam logic [CfgWidth-1:0] DebounceReset  = 16'd50;
  localparam logic [CfgWidth-1:0] ClickMaxReset  = 16'd300;
  localparam logic [CfgWidth-1:0] ShortMaxReset  = 16'd1000;
  localparam logic [CfgWidth-1:0] LongHoldReset  = 16'd3000;
  localparam logic [CfgWidth-1:0] DoubleGapReset = 16'd500;

endpackage

/* rtl/bgc_debounce.sv */
module bgc_debounce import bgc_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic                level_i,
  input  logic [CfgWidth-1:0] debounce_ms_i,
  output logic                level_o,
  output logic                trusted_o
);

  localparam int unsigned CmpWidth = (COUNT_WIDTH > CfgWidth) ? COUNT_WIDTH : CfgWidth;

  logic                   last_level_q, last_level_d;
  logic [COUNT_WIDTH-1:0] stable_q, stable_d;

  always_comb begin
    last_level_d = last_level_q;
    stable_d     = stable_q;
    if (level_i != last_level_q) begin
      last_level_d = level_i;
      stable_d     = '0;
    end else if (stable_q != '1) begin
      stable_d = stable_q + COUNT_WIDTH'(1);
    end
  end

  // Both sides are widened so a register beyond the counter range never matches.
  assign level_o   = last_level_d;
  assign trusted_o = CmpWidth'(stable_d) > CmpWidth'(debounce_ms_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_level_q <= 1'b1;
      stable_q     <= '0;
    end else if (step_i) begin
      last_level_q <= last_level_d;
      stable_q     <= stable_d;
    end
  end

endmodule

/* rtl/button_gesture_classifier.sv */
// Push-button gesture classifier.
// Each input transfer is one millisecond tick carrying the raw button level
// (0 pressed) and a flag that reads and clears the pending event. Every tick
// produces exactly one result transfer: the event code (nonzero only when the
// tick asked for it) and the debounced pressed state after the tick.
// The tick updates all state in the cycle it is accepted, and its result sits
// in the output register from the next cycle on; a new tick is taken every
// cycle while the receiver is ready. The state update loop (counters,
// compares, classification) is combinational.
// When the receiver stalls, a waiting result holds in the output register and
// in_ready_o drops; it is high only while that register is empty or is being
// emptied in the same cycle, so the input waits without loss.
// Reset restores the register defaults (50, 300, 1000, 3000, 500 ms), marks
// the button released, clears all counters and drops any pending event.
// Configuration writes take effect at the next edge and should be made while
// no tick is in flight.
module button_gesture_classifier import bgc_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   switch_level_i,
  input  logic                   take_event_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [2:0]             event_code_o,
  output logic                   pressed_now_o,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [CfgWidth-1:0]    cfg_wdata_i
);

  localparam int unsigned CmpWidth = (COUNT_WIDTH > CfgWidth) ? COUNT_WIDTH : CfgWidth;

  logic [CfgWidth-1:0] debounce_q, click_max_q, short_max_q, long_hold_q, double_gap_q;

  logic                   press_active_q, press_active_d;
  logic [COUNT_WIDTH-1:0] press_ticks_q, press_ticks_d;
  logic                   long_rep_q, long_rep_d;
  logic                   awaiting_q, awaiting_d;
  logic [COUNT_WIDTH-1:0] gap_ticks_q, gap_ticks_d;
  event_code_e            pending_q, pending_d;

  logic        out_valid_q;
  event_code_e code_q, code_d;
  logic        pressed_q;

  logic accept;
  logic level;
  logic trusted;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  bgc_debounce #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_debounce (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (accept),
    .level_i      (switch_level_i),
    .debounce_ms_i(debounce_q),
    .level_o      (level),
    .trusted_o    (trusted)
  );

  always_comb begin
    press_active_d = press_active_q;
    press_ticks_d  = press_ticks_q;
    long_rep_d     = long_rep_q;
    awaiting_d     = awaiting_q;
    gap_ticks_d    = gap_ticks_q;
    pending_d      = pending_q;
    code_d         = EV_NONE;

    if (press_active_q && press_ticks_q != '1) begin
      press_ticks_d = press_ticks_q + COUNT_WIDTH'(1);
    end
    if (awaiting_q && gap_ticks_q != '1) begin
      gap_ticks_d = gap_ticks_q + COUNT_WIDTH'(1);
    end

    if (trusted) begin
      if (!level && !press_active_d) begin
        press_active_d = 1'b1;
        press_ticks_d  = '0;
        long_rep_d     = 1'b0;
      end
      // A press that just started is checked too, so a zero threshold fires at once.
      if (!level && press_active_d) begin
        if (CmpWidth'(press_ticks_d) >= CmpWidth'(long_hold_q) && !long_rep_d) begin
          pending_d  = EV_LONG;
          long_rep_d = 1'b1;
        end
      end
      if (level && press_active_d) begin
        if (CmpWidth'(press_ticks_d) < CmpWidth'(click_max_q)) begin
          if (awaiting_d && CmpWidth'(gap_ticks_d) < CmpWidth'(double_gap_q)) begin
            pending_d  = EV_DOUBLE;
            awaiting_d = 1'b0;
          end else begin
            awaiting_d  = 1'b1;
            gap_ticks_d = '0;
          end
        end else if (CmpWidth'(press_ticks_d) < CmpWidth'(short_max_q)) begin
          pending_d = EV_SHORT;
        end else if (!long_rep_d) begin
          pending_d = EV_LONG;
        end
        press_active_d = 1'b0;
        long_rep_d     = 1'b0;
      end
    end

    if (awaiting_d && CmpWidth'(gap_ticks_d) > CmpWidth'(double_gap_q)) begin
      awaiting_d = 1'b0;
      pending_d  = EV_CLICK;
    end

    if (take_event_i) begin
      code_d    = pending_d;
      pending_d = EV_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= DebounceReset;
      click_max_q  <= ClickMaxReset;
      short_max_q  <= ShortMaxReset;
      long_hold_q  <= LongHoldReset;
      double_gap_q <= DoubleGapReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DEBOUNCE:   debounce_q   <= cfg_wdata_i;
        CFG_CLICK_MAX:  click_max_q  <= cfg_wdata_i;
        CFG_SHORT_MAX:  short_max_q  <= cfg_wdata_i;
        CFG_LONG_HOLD:  long_hold_q  <= cfg_wdata_i;
        CFG_DOUBLE_GAP: double_gap_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_active_q <= 1'b0;
      press_ticks_q  <= '0;
      long_rep_q     <= 1'b0;
      awaiting_q     <= 1'b0;
      gap_ticks_q    <= '0;
      pending_q      <= EV_NONE;
    end else if (accept) begin
      press_active_q <= press_active_d;
      press_ticks_q  <= press_ticks_d;
      long_rep_q     <= long_rep_d;
      awaiting_q     <= awaiting_d;
      gap_ticks_q    <= gap_ticks_d;
      pending_q      <= pending_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      code_q    <= code_d;
      pressed_q <= press_active_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_code_o  = code_q;
  assign pressed_now_o = pressed_q;

endmodule
